### sv/bus_pkg.sv
// shared types and constants for the bounded undo stack
package bus_pkg;

   // field widths of one undo record
   localparam int POS_W    = 64;
   localparam int CURSOR_W = 32;
   localparam int NIBBLE_W = 1;
   localparam int BYTE_W   = 8;
   localparam int REC_W    = POS_W + CURSOR_W + NIBBLE_W + BYTE_W;

   // depth register
   localparam int               CFG_W       = 9;
   localparam logic [CFG_W-1:0] DEPTH_RESET = 9'd256;

   // operation codes
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   // command from the sequencer to the pointer unit
   typedef struct packed {
      logic fire;
      logic is_push;
   } ptr_cmd_type;

endpackage

### sv/bus_if.sv
// handshake interfaces for request, response and register write channels
interface bus_req_if
   import bus_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic signed [POS_W-1:0]    push_file_position;
   logic signed [CURSOR_W-1:0] push_cursor_offset;
   logic [NIBBLE_W-1:0]        push_nibble;
   logic [BYTE_W-1:0]          push_byte;

   modport source (output valid, kind, push_file_position, push_cursor_offset,
                   push_nibble, push_byte, input ready);
   modport sink (input valid, kind, push_file_position, push_cursor_offset,
                 push_nibble, push_byte, output ready);
endinterface

interface bus_rsp_if
   import bus_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic                       success;
   logic signed [POS_W-1:0]    popped_file_position;
   logic signed [CURSOR_W-1:0] popped_cursor_offset;
   logic [NIBBLE_W-1:0]        popped_nibble;
   logic [BYTE_W-1:0]          popped_byte;

   modport source (output valid, success, popped_file_position, popped_cursor_offset,
                   popped_nibble, popped_byte, input ready);
   modport sink (input valid, success, popped_file_position, popped_cursor_offset,
                 popped_nibble, popped_byte, output ready);
endinterface

interface bus_csr_if
   import bus_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### sv/bus_ram.sv
// generic single-port-write, registered-read ram
module bus_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bus_ptr.sv
// ring pointer unit: base slot, record count and slot selection
module bus_ptr
   import bus_pkg::*;
#(
   parameter int MAX_RECORDS = 256,
   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
   localparam int CW = $clog2(MAX_RECORDS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] depth,
   input  ptr_cmd_type      cmd,
   output logic             ok,
   output logic [AW-1:0]    slot
);

   localparam int DW = (CW > CFG_W) ? CW : CFG_W;
   localparam int SW = CW + 1;
   localparam logic [DW-1:0] MAX_D = DW'(MAX_RECORDS);
   localparam logic [SW-1:0] MAX_S = SW'(MAX_RECORDS);

   logic [AW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] held_ff, held_in;

   logic [DW-1:0] cfg_ext, eff, held_ext, drop;
   logic          full;
   logic [CW-1:0] offset;
   logic [SW-1:0] slot_sum, base_sum;

   // effective depth and fullness
   always_comb begin
      cfg_ext  = DW'(depth);
      eff      = (cfg_ext > MAX_D) ? MAX_D : cfg_ext;
      held_ext = DW'(held_ff);
      full     = (held_ext >= eff);
      drop     = held_ext - eff + DW'(1);
   end

   // slot of the new top on push, or of the current top on pop
   always_comb begin
      ok       = (eff != '0) && (cmd.is_push || (held_ff != '0));
      offset   = cmd.is_push ? held_ff : (held_ff - CW'(1));
      slot_sum = SW'(oldest_ff) + SW'(offset);
      if (slot_sum >= MAX_S) begin
         slot_sum = slot_sum - MAX_S;
      end
      slot = slot_sum[AW-1:0];
   end

   // next base and count
   always_comb begin
      oldest_in = oldest_ff;
      held_in   = held_ff;
      base_sum  = SW'(oldest_ff) + SW'(drop[CW-1:0]);
      if (base_sum >= MAX_S) begin
         base_sum = base_sum - MAX_S;
      end
      if (cmd.fire && ok) begin
         if (cmd.is_push) begin
            if (full) begin
               oldest_in = base_sum[AW-1:0];
               held_in   = eff[CW-1:0];
            end else begin
               held_in = held_ff + CW'(1);
            end
         end else begin
            held_in = held_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         held_ff   <= '0;
      end else begin
         oldest_ff <= oldest_in;
         held_ff   <= held_in;
      end
   end

   // count never exceeds the ring size
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(MAX_RECORDS))
      else $error("record count above ring size");

   // a successful pop removes exactly one record
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.fire && ok && !cmd.is_push |=> held_ff == $past(held_ff) - CW'(1))
      else $error("pop did not decrement count");

   // the base only moves on a push into a full ring
   a_base_move: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fire && ok && cmd.is_push && full) |=> oldest_ff == $past(oldest_ff))
      else $error("base slot moved unexpectedly");

endmodule

### sv/bounded_undo_stack_top.sv
// bounded undo stack: ring of undo records with drop-oldest push and pop
// a push or failed op goes from idle straight to the response state, while a pop
// passes through the ram read state first; a new request is taken only in idle,
//    i.e. only once the ram read and the held response register have cleared
// reset: synchronous; clears count and base slot, depth register to 256
// record ram contents are not cleared and are only read after being written
module bounded_undo_stack_top
   import bus_pkg::*;
#(
   parameter int MAX_RECORDS = 256,
   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
   input  logic    clock,
   input  logic    reset,
   bus_req_if.sink   req_chan,
   bus_rsp_if.source rsp_chan,
   bus_csr_if.sink   csr_chan
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0] depth_ff;
   ptr_cmd_type      cmd;
   logic             ok;
   logic [AW-1:0]    slot;
   logic             accept;
   logic             wr_en, rd_en;
   logic [REC_W-1:0] wr_data, rd_data;

   logic                       success_ff;
   logic signed [POS_W-1:0]    pos_ff;
   logic signed [CURSOR_W-1:0] cursor_ff;
   logic [NIBBLE_W-1:0]        nibble_ff;
   logic [BYTE_W-1:0]          byte_ff;

   // depth register
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
      end else if (csr_chan.valid) begin
         depth_ff <= csr_chan.data;
      end
   end

   // request handshake and pointer command
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign cmd.fire       = accept;
   assign cmd.is_push    = (req_chan.kind == KIND_PUSH);

   bus_ptr #(.MAX_RECORDS(MAX_RECORDS)) u_ptr (
      .clock (clock),
      .reset (reset),
      .depth (depth_ff),
      .cmd   (cmd),
      .ok    (ok),
      .slot  (slot)
   );

   // record ram access
   assign wr_en   = accept && cmd.is_push && ok;
   assign rd_en   = accept && !cmd.is_push && ok;
   assign wr_data = {req_chan.push_file_position, req_chan.push_cursor_offset,
                     req_chan.push_nibble, req_chan.push_byte};

   bus_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = rd_en ? ST_READ : ST_RESP;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (accept) begin
         success_ff <= ok;
         pos_ff     <= '0;
         cursor_ff  <= '0;
         nibble_ff  <= '0;
         byte_ff    <= '0;
      end else if (state_ff == ST_READ) begin
         {pos_ff, cursor_ff, nibble_ff, byte_ff} <= rd_data;
      end
   end

   assign rsp_chan.valid                = (state_ff == ST_RESP);
   assign rsp_chan.success              = success_ff;
   assign rsp_chan.popped_file_position = pos_ff;
   assign rsp_chan.popped_cursor_offset = cursor_ff;
   assign rsp_chan.popped_nibble        = nibble_ff;
   assign rsp_chan.popped_byte          = byte_ff;

   // a pop read always completes into the response stage
   a_read_then_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_RESP)
      else $error("ram read not followed by response");

   // no request is taken while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request accepted with response pending");

   // a failed operation returns an all-zero record
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.success |->
         rsp_chan.popped_file_position == '0 && rsp_chan.popped_byte == '0)
      else $error("failed operation returned data");

   // a successful pop request always goes through the ram read
   a_pop_reads: assert property (@(posedge clock) disable iff (reset)
      accept && !cmd.is_push && ok |=> state_ff == ST_READ)
      else $error("pop skipped ram read");

endmodule
